// ===== hdl/crs_pkg.sv =====
package crs_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int PT_W       = 32;
  localparam int KNOT_W     = 31;
  localparam int U_W        = 17;
  localparam int NUM_W      = 58;
  localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
  localparam int MUL_W      = 34;
  localparam int ACC_W      = 72;
  localparam int S_W        = 19;
  localparam int S2_W       = 20;
  localparam int S3_W       = 21;
  localparam int COEF_W     = 24;
  localparam int INNER_W    = 40;
  localparam int LO_W       = 20;

  localparam logic [U_W-1:0]           ONE_Q16   = 17'd65536;
  localparam logic [KNOT_W-1:0]        TENTH_Q16 = 31'd6554;
  localparam logic signed [S_W-1:0]    S_LIMIT   = 19'sd131072;
  localparam logic signed [ACC_W-1:0]  MUL_LIMIT = {{(ACC_W-61){1'b0}}, 1'b1, 60'd0};

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_FEW   = 2'd2,
    ST_ORDER = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0][PT_W-1:0] p;
    logic [KNOT_W-1:0]    knot;
    logic [2:0][PT_W-1:0] tan;
  } row_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [5:0] {
    S_IDLE, S_FIN,
    S_A_CHK, S_A_PP, S_A_DA, S_A_WA, S_A_WB, S_A_WR,
    S_E_LAST, S_E_W, S_E_SC, S_E_R0, S_E_R1, S_E_SD, S_E_SW,
    S_E_M1, S_E_M2, S_E_M3, S_E_M4,
    S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
    S_D1, S_D2, S_D3, S_D4, S_D5
  } state_t;

  function automatic logic signed [PT_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (&v[ACC_W-1:PT_W-1]) || (~|v[ACC_W-1:PT_W-1]);
    if (fits) return v[PT_W-1:0];
    else if (v[ACC_W-1]) return {1'b1, {(PT_W-1){1'b0}}};
    else return {1'b0, {(PT_W-1){1'b1}}};
  endfunction

endpackage

// ===== hdl/catmull_rom_spline_evaluator.sv =====
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | func, px, py, pz, knot, u_frac, derivative
// out     | output    | out_valid / out_ready | rx, ry, rz, status
//
// Appends that update a tangent run two divisions per axis; other appends and rejected
// items need no division. Evaluation runs the knot search, one division for s, and
// one more per axis for a derivative; divisions use the 58-step bit-serial divider.
// The knot search reads one table row per cycle.
// One item at a time; the result register lets the next item in while a result waits.
// Reset is synchronous and clears the point count; the table needs no clearing pass.
module catmull_rom_spline_evaluator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic signed [crs_pkg::PT_W-1:0]   in_px,
  input  logic signed [crs_pkg::PT_W-1:0]   in_py,
  input  logic signed [crs_pkg::PT_W-1:0]   in_pz,
  input  logic [crs_pkg::KNOT_W-1:0]        in_knot,
  input  logic [crs_pkg::U_W-1:0]           in_u_frac,
  input  logic                              in_derivative,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [crs_pkg::PT_W-1:0]   out_rx,
  output logic signed [crs_pkg::PT_W-1:0]   out_ry,
  output logic signed [crs_pkg::PT_W-1:0]   out_rz,
  output logic [1:0]                        out_status
);
  import crs_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]            cnt_r, c_r, cnt_m1, c_m1, c_m2, last;
  logic [2:0][PT_W-1:0]        np_r, tan_r, res_r;
  logic [KNOT_W-1:0]           k_r, weight_r, h_r;
  logic [U_W-1:0]              u_r;
  logic                        deriv_r;
  logic [1:0]                  axis_r;
  logic [IDX_W-1:0]            idx_r, seg_i;
  row_t                        prv_r, pp_r, r0_r, r1_r, rd_row, new_row, upd_row;
  status_t                     status_r;
  logic signed [NUM_W-1:0]     sa_r;
  logic signed [S_W-1:0]       s_r;
  logic signed [S2_W-1:0]      s2_r;
  logic signed [S3_W-1:0]      s3_r;
  logic signed [ACC_W-1:0]     acc_r, prod_x, acc_clamp;
  logic signed [2*MUL_W-1:0]   mul_p_r;
  logic signed [MUL_W-1:0]     mul_a, mul_b;
  logic                        out_valid_r, out_free;

  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr, rd_addr;
  row_t                        mem_wdata;

  logic                        div_start;
  logic signed [NUM_W-1:0]     div_num, div_quo;
  logic [KNOT_W-1:0]           div_den;
  div_stat_t                   div_st;

  logic                        order_bad, search_go;
  logic signed [PT_W-1:0]      p0, p1, t0, t1, pa, pb, pc;
  logic signed [PT_W:0]        dd, da, db;
  logic signed [PT_W-1:0]      t_s;
  logic signed [COEF_W-1:0]    sx, s2x, s3x, b01, b10, b11, d01, d10, d11;
  logic signed [INNER_W-1:0]   inner;

  crs_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (rd_row)
  );

  crs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_st),
    .quo   (div_quo)
  );

  always_comb begin
    cnt_m1    = cnt_r - 1'b1;
    c_m1      = c_r - 1'b1;
    c_m2      = c_r - CNT_W'(2);
    last      = cnt_m1;
    out_free  = !out_valid_r || out_ready;
    order_bad = (c_r != '0) && (k_r <= rd_row.knot);
    search_go = (CNT_W'(idx_r) < last) && (weight_r > rd_row.knot);
    seg_i     = (weight_r < TENTH_Q16 || idx_r == '0) ? IDX_W'(1) : idx_r;
    prod_x    = {{(ACC_W-2*MUL_W){mul_p_r[2*MUL_W-1]}}, mul_p_r};
    inner     = INNER_W'(acc_r >>> 16);
    if (acc_r > MUL_LIMIT) acc_clamp = MUL_LIMIT;
    else if (acc_r < -MUL_LIMIT) acc_clamp = -MUL_LIMIT;
    else acc_clamp = acc_r;

    p0  = $signed(r0_r.p[axis_r]);
    p1  = $signed(r1_r.p[axis_r]);
    t0  = $signed(r0_r.tan[axis_r]);
    t1  = $signed(r1_r.tan[axis_r]);
    dd  = (PT_W+1)'(p1) - (PT_W+1)'(p0);
    pa  = $signed(pp_r.p[axis_r]);
    pb  = $signed(prv_r.p[axis_r]);
    pc  = $signed(np_r[axis_r]);
    da  = (PT_W+1)'(pb) - (PT_W+1)'(pa);
    db  = (PT_W+1)'(pc) - (PT_W+1)'(pb);
    t_s = $signed({1'b0, weight_r}) - $signed({1'b0, r0_r.knot});

    sx  = COEF_W'(s_r);
    s2x = COEF_W'(s2_r);
    s3x = COEF_W'(s3_r);
    b01 = (s2x <<< 1) + s2x - (s3x <<< 1);
    b10 = s3x - (s2x <<< 1) + sx;
    b11 = s3x - s2x;
    d01 = (sx <<< 2) + (sx <<< 1) - (s2x <<< 2) - (s2x <<< 1);
    d10 = (s2x <<< 1) + s2x - (sx <<< 2) + $signed(COEF_W'(ONE_Q16));
    d11 = (s2x <<< 1) + s2x - (sx <<< 1);

    new_row.p    = np_r;
    new_row.knot = k_r;
    new_row.tan  = '0;
    upd_row      = prv_r;
    upd_row.tan  = tan_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_func == FUNC_ADD) begin
            state_nxt = (cnt_r >= CNT_W'(MAX_POINTS)) ? S_FIN : S_A_CHK;
          end else begin
            state_nxt = (cnt_r < CNT_W'(2)) ? S_FIN : S_E_LAST;
          end
        end
      end
      S_A_CHK: begin
        if (order_bad || c_r < CNT_W'(2)) state_nxt = S_FIN;
        else state_nxt = S_A_PP;
      end
      S_A_PP:   state_nxt = S_A_DA;
      S_A_DA:   state_nxt = S_A_WA;
      S_A_WA:   if (div_st.done) state_nxt = S_A_WB;
      S_A_WB:   if (div_st.done) state_nxt = (axis_r == 2'd2) ? S_A_WR : S_A_DA;
      S_A_WR:   state_nxt = S_FIN;
      S_E_LAST: state_nxt = S_E_W;
      S_E_W:    state_nxt = S_E_SC;
      S_E_SC:   if (!search_go) state_nxt = S_E_R0;
      S_E_R0:   state_nxt = S_E_R1;
      S_E_R1:   state_nxt = S_E_SD;
      S_E_SD:   state_nxt = S_E_SW;
      S_E_SW:   if (div_st.done) state_nxt = S_E_M1;
      S_E_M1:   state_nxt = S_E_M2;
      S_E_M2:   state_nxt = S_E_M3;
      S_E_M3:   state_nxt = S_E_M4;
      S_E_M4:   state_nxt = deriv_r ? S_D1 : S_P1;
      S_P1:     state_nxt = S_P2;
      S_P2:     state_nxt = S_P3;
      S_P3:     state_nxt = S_P4;
      S_P4:     state_nxt = S_P5;
      S_P5:     state_nxt = S_P6;
      S_P6:     state_nxt = S_P7;
      S_P7:     state_nxt = S_P8;
      S_P8:     state_nxt = (axis_r == 2'd2) ? S_FIN : S_P1;
      S_D1:     state_nxt = S_D2;
      S_D2:     state_nxt = S_D3;
      S_D3:     state_nxt = S_D4;
      S_D4:     state_nxt = S_D5;
      S_D5:     if (div_st.done) state_nxt = (axis_r == 2'd2) ? S_FIN : S_D1;
      S_FIN:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = c_r[IDX_W-1:0];
    mem_wdata = new_row;
    rd_addr   = '0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = cnt_m1[IDX_W-1:0];
      end
      S_A_CHK: begin
        if (!order_bad) begin
          mem_we  = 1'b1;
          rd_addr = c_m2[IDX_W-1:0];
        end
      end
      S_A_DA: begin
        div_start = 1'b1;
        div_num   = NUM_W'(da) <<< 16;
        div_den   = prv_r.knot - pp_r.knot;
      end
      S_A_WA: begin
        if (div_st.done) begin
          div_start = 1'b1;
          div_num   = NUM_W'(db) <<< 16;
          div_den   = k_r - prv_r.knot;
        end
      end
      S_A_WR: begin
        mem_we    = 1'b1;
        mem_waddr = c_m1[IDX_W-1:0];
        mem_wdata = upd_row;
      end
      S_E_LAST: begin
        mul_a = MUL_W'({1'b0, rd_row.knot});
        mul_b = MUL_W'({1'b0, u_r});
      end
      S_E_SC: rd_addr = search_go ? idx_r + 1'b1 : seg_i - 1'b1;
      S_E_R0: rd_addr = idx_r;
      S_E_SD: begin
        div_start = 1'b1;
        div_num   = NUM_W'(t_s) <<< 16;
        div_den   = r1_r.knot - r0_r.knot;
      end
      S_E_M1: begin
        mul_a = MUL_W'(s_r);
        mul_b = MUL_W'(s_r);
      end
      S_E_M3: begin
        mul_a = MUL_W'(s2_r);
        mul_b = MUL_W'(s_r);
      end
      S_P1: begin
        mul_a = MUL_W'(b10);
        mul_b = MUL_W'(t0);
      end
      S_P2: begin
        mul_a = MUL_W'(b11);
        mul_b = MUL_W'(t1);
      end
      S_P4: begin
        mul_a = MUL_W'($signed(inner[INNER_W-1:LO_W]));
        mul_b = MUL_W'({1'b0, h_r});
      end
      S_P5: begin
        mul_a = MUL_W'({1'b0, inner[LO_W-1:0]});
        mul_b = MUL_W'({1'b0, h_r});
      end
      S_P7: begin
        mul_a = MUL_W'(b01);
        mul_b = MUL_W'(dd);
      end
      S_D1: begin
        mul_a = MUL_W'(d01);
        mul_b = MUL_W'(dd);
      end
      S_D2: begin
        div_start = 1'b1;
        div_num   = $signed(prod_x[NUM_W-1:0]);
        div_den   = h_r;
        mul_a     = MUL_W'(d10);
        mul_b     = MUL_W'(t0);
      end
      S_D3: begin
        mul_a = MUL_W'(d11);
        mul_b = MUL_W'(t1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_A_CHK && !order_bad) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          np_r     <= {in_pz, in_py, in_px};
          k_r      <= in_knot;
          u_r      <= (in_u_frac > ONE_Q16) ? ONE_Q16 : in_u_frac;
          deriv_r  <= in_derivative;
          c_r      <= cnt_r;
          res_r    <= '0;
          axis_r   <= '0;
          status_r <= (in_func == FUNC_ADD && cnt_r >= CNT_W'(MAX_POINTS)) ? ST_FULL :
                      (in_func == FUNC_EVAL && cnt_r < CNT_W'(2)) ? ST_FEW : ST_OK;
        end
      end
      S_A_CHK: begin
        prv_r <= rd_row;
        tan_r <= '0;
        if (order_bad) status_r <= ST_ORDER;
      end
      S_A_PP: pp_r <= rd_row;
      S_A_WA: if (div_st.done) sa_r <= div_quo;
      S_A_WB: begin
        if (div_st.done) begin
          tan_r[axis_r] <= sat32((ACC_W'(sa_r) + ACC_W'(div_quo)) >>> 1);
          axis_r        <= axis_r + 1'b1;
        end
      end
      S_E_W: begin
        weight_r <= KNOT_W'(mul_p_r >>> 16);
        idx_r    <= '0;
      end
      S_E_SC: idx_r <= search_go ? idx_r + 1'b1 : seg_i;
      S_E_R0: r0_r <= rd_row;
      S_E_R1: r1_r <= rd_row;
      S_E_SD: h_r <= r1_r.knot - r0_r.knot;
      S_E_SW: begin
        if (div_st.done) begin
          if (div_quo > NUM_W'(S_LIMIT)) s_r <= S_LIMIT;
          else if (div_quo < -NUM_W'(S_LIMIT)) s_r <= -S_LIMIT;
          else s_r <= S_W'(div_quo);
        end
      end
      S_E_M2: s2_r <= S2_W'(mul_p_r >>> 16);
      S_E_M4: s3_r <= S3_W'(mul_p_r >>> 16);
      S_P2:   acc_r <= prod_x;
      S_P3:   acc_r <= acc_r + prod_x;
      S_P5:   acc_r <= prod_x <<< LO_W;
      S_P6:   acc_r <= acc_r + prod_x;
      S_P7:   acc_r <= acc_clamp >>> 16;
      S_P8: begin
        res_r[axis_r] <= sat32(ACC_W'(p0) + (prod_x >>> 16) + acc_r);
        axis_r        <= axis_r + 1'b1;
      end
      S_D3:   acc_r <= prod_x;
      S_D4:   acc_r <= acc_r + prod_x;
      S_D5: begin
        if (div_st.done) begin
          res_r[axis_r] <= sat32(ACC_W'(div_quo) + (acc_r >>> 16));
          axis_r        <= axis_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  logic signed [PT_W-1:0] orx_r, ory_r, orz_r;
  status_t                ost_r;

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      orx_r <= res_r[0];
      ory_r <= res_r[1];
      orz_r <= res_r[2];
      ost_r <= status_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_rx     = orx_r;
  assign out_ry     = ory_r;
  assign out_rz     = orz_r;
  assign out_status = ost_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS))
    else $error("point count beyond table depth");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_A_CHK || state_r == S_A_WR))
    else $error("table write outside append");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while busy");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (out_valid && state_r == S_IDLE))
    else $error("result not presented");

endmodule

// ===== hdl/crs_store.sv =====
module crs_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic [crs_pkg::IDX_W-1:0] waddr,
  input  crs_pkg::row_t             wdata,
  input  logic [crs_pkg::IDX_W-1:0] raddr,
  output crs_pkg::row_t             rdata
);
  import crs_pkg::*;

  row_t mem [MAX_POINTS];
  row_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/crs_div.sv =====
module crs_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [crs_pkg::NUM_W-1:0]  num,
  input  logic [crs_pkg::KNOT_W-1:0]        den,
  output crs_pkg::div_stat_t                stat,
  output logic signed [crs_pkg::NUM_W-1:0]  quo
);
  import crs_pkg::*;

  logic [NUM_W-1:0]     mag_r, mag_nxt;
  logic [KNOT_W-1:0]    rem_r, rem_nxt, den_r;
  logic [KNOT_W:0]      rem_sh;
  logic                 take, neg_r, zero_r, busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  always_comb begin
    rem_sh  = {rem_r, mag_r[NUM_W-1]};
    take    = rem_sh >= {1'b0, den_r};
    rem_nxt = take ? KNOT_W'(rem_sh - {1'b0, den_r}) : rem_sh[KNOT_W-1:0];
    mag_nxt = {mag_r[NUM_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == DIV_CNT_W'(1));
      if (start && !busy_r) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      mag_r  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem_r  <= '0;
      den_r  <= den;
      neg_r  <= num[NUM_W-1];
      zero_r <= (den == '0);
      cnt_r  <= DIV_CNT_W'(NUM_W);
    end else if (busy_r) begin
      mag_r <= mag_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo = zero_r ? '0 : (neg_r ? -$signed(mag_r) : $signed(mag_r));

endmodule

// ===== tb/catmull_rom_spline_evaluator_tb.sv =====
module catmull_rom_spline_evaluator_tb;
  import crs_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 600;
  localparam longint Q16_ONE = 65536;
  localparam longint TENTH = 6554;
  localparam longint S_CLAMP = 131072;

  typedef struct {
    logic [PT_W-1:0] rx;
    logic [PT_W-1:0] ry;
    logic [PT_W-1:0] rz;
    status_t st;
  } spline_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = FUNC_ADD;
  logic signed [PT_W-1:0] in_px = '0;
  logic signed [PT_W-1:0] in_py = '0;
  logic signed [PT_W-1:0] in_pz = '0;
  logic [KNOT_W-1:0] in_knot = '0;
  logic [U_W-1:0] in_u_frac = '0;
  logic in_derivative = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [PT_W-1:0] out_rx;
  logic signed [PT_W-1:0] out_ry;
  logic signed [PT_W-1:0] out_rz;
  logic [1:0] out_status;

  catmull_rom_spline_evaluator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_px(in_px), .in_py(in_py), .in_pz(in_pz), .in_knot(in_knot),
    .in_u_frac(in_u_frac), .in_derivative(in_derivative),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_rx(out_rx), .out_ry(out_ry), .out_rz(out_rz), .out_status(out_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // curve table mirror
  logic signed [PT_W-1:0] ctrl_pt [MAX_POINTS][3];
  logic signed [PT_W-1:0] ctrl_tan [MAX_POINTS][3];
  logic [KNOT_W-1:0] ctrl_knot [MAX_POINTS];
  int ctrl_count = 0;

  spline_result_t expected_results[$];
  int errors = 0;
  int n_checked = 0;
  int n_appends = 0;
  int n_evals = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int cycles = 0;
  int burst_left = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  function automatic longint fl_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint trunc_div(longint n, longint d);
    return (d == 0) ? 0 : n / d;
  endfunction

  function automatic longint clamp_mul(longint a, longint b);
    longint unsigned ua, ub, lim;
    lim = 64'd1 << 60;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    if (ua != 0 && ub > lim / ua) return ((a < 0) != (b < 0)) ? -longint'(lim) : longint'(lim);
    return a * b;
  endfunction

  function automatic logic [PT_W-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[PT_W-1:0];
  endfunction

  function automatic logic [PT_W-1:0] chord_mean(longint pa, longint pb, longint pc,
                                                 longint ha, longint hb);
    longint sa, sb;
    sa = trunc_div((pb - pa) * Q16_ONE, ha);
    sb = trunc_div((pc - pb) * Q16_ONE, hb);
    return clamp32(fl_shift(sa + sb, 1));
  endfunction

  function automatic longint hermite_eval(longint p0, longint p1, longint t0, longint t1,
                                          longint s, longint h, bit deriv);
    longint s2, s3, d, b01, b10, b11, inner;
    s2 = fl_shift(s * s, 16);
    s3 = fl_shift(s2 * s, 16);
    d = p1 - p0;
    if (!deriv) begin
      b01 = 3 * s2 - 2 * s3;
      b10 = s3 - 2 * s2 + s;
      b11 = s3 - s2;
      inner = fl_shift(b10 * t0 + b11 * t1, 16);
      return p0 + fl_shift(b01 * d, 16) + fl_shift(clamp_mul(inner, h), 16);
    end
    b01 = 6 * s - 6 * s2;
    b10 = 3 * s2 - 4 * s + Q16_ONE;
    b11 = 3 * s2 - 2 * s;
    return trunc_div(b01 * d, h) + fl_shift(b10 * t0 + b11 * t1, 16);
  endfunction

  function automatic spline_result_t spline_predict(logic func, logic signed [PT_W-1:0] x,
      logic signed [PT_W-1:0] y, logic signed [PT_W-1:0] z, logic [KNOT_W-1:0] k,
      logic [U_W-1:0] u_in, logic deriv);
    spline_result_t r;
    longint u, weight, t, h, s, ha, hb;
    int c, last, i, a;
    r.rx = '0;
    r.ry = '0;
    r.rz = '0;
    r.st = ST_OK;
    c = ctrl_count;
    if (func == FUNC_ADD) begin
      if (c >= MAX_POINTS) begin
        r.st = ST_FULL;
      end else if (c >= 1 && k <= ctrl_knot[c-1]) begin
        r.st = ST_ORDER;
      end else begin
        ctrl_pt[c][0] = x;
        ctrl_pt[c][1] = y;
        ctrl_pt[c][2] = z;
        ctrl_knot[c] = k;
        for (a = 0; a < 3; a++) ctrl_tan[c][a] = '0;
        if (c >= 2) begin
          hb = longint'(k) - longint'(ctrl_knot[c-1]);
          ha = longint'(ctrl_knot[c-1]) - longint'(ctrl_knot[c-2]);
          for (a = 0; a < 3; a++)
            ctrl_tan[c-1][a] = chord_mean(ctrl_pt[c-2][a], ctrl_pt[c-1][a], ctrl_pt[c][a],
                                          ha, hb);
        end
        ctrl_count = c + 1;
      end
    end else if (c < 2) begin
      r.st = ST_FEW;
    end else begin
      u = longint'(u_in);
      if (u > Q16_ONE) u = Q16_ONE;
      last = c - 1;
      weight = (longint'(ctrl_knot[last]) * u) >>> 16;
      i = 0;
      while (i < last && weight > longint'(ctrl_knot[i])) i++;
      if (weight < TENTH || i == 0) i = 1;
      t = weight - longint'(ctrl_knot[i-1]);
      h = longint'(ctrl_knot[i]) - longint'(ctrl_knot[i-1]);
      s = trunc_div(t * Q16_ONE, h);
      if (s > S_CLAMP) s = S_CLAMP;
      if (s < -S_CLAMP) s = -S_CLAMP;
      r.rx = clamp32(hermite_eval(ctrl_pt[i-1][0], ctrl_pt[i][0], ctrl_tan[i-1][0],
                                  ctrl_tan[i][0], s, h, deriv));
      r.ry = clamp32(hermite_eval(ctrl_pt[i-1][1], ctrl_pt[i][1], ctrl_tan[i-1][1],
                                  ctrl_tan[i][1], s, h, deriv));
      r.rz = clamp32(hermite_eval(ctrl_pt[i-1][2], ctrl_pt[i][2], ctrl_tan[i-1][2],
                                  ctrl_tan[i][2], s, h, deriv));
    end
    return r;
  endfunction

  task automatic send_item(logic func, logic [PT_W-1:0] x, logic [PT_W-1:0] y,
                           logic [PT_W-1:0] z, logic [KNOT_W-1:0] k,
                           logic [U_W-1:0] u, logic deriv);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_func <= func;
    in_px <= x;
    in_py <= y;
    in_pz <= z;
    in_knot <= k;
    in_u_frac <= u;
    in_derivative <= deriv;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(spline_predict(func, x, y, z, k, u, deriv));
    if (func == FUNC_ADD) n_appends++;
    else n_evals++;
  endtask

  function automatic logic [PT_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h1fffff) - 32'h100000;
    endcase
  endfunction

  task automatic append_point(logic [PT_W-1:0] x, logic [PT_W-1:0] y, logic [PT_W-1:0] z,
                              logic [KNOT_W-1:0] k);
    send_item(FUNC_ADD, x, y, z, k, U_W'($urandom), 1'($urandom));
  endtask

  task automatic evaluate(logic [U_W-1:0] u, logic deriv);
    send_item(FUNC_EVAL, $urandom, $urandom, $urandom, KNOT_W'($urandom), u, deriv);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_too_few_points();
    evaluate(17'd0, 1'b0);
    append_point(32'h80000000, 32'h7fffffff, 32'h0, 31'd3);
    evaluate(17'd65536, 1'b1);
    append_point(32'h1, 32'h2, 32'h3, 31'd3);
    append_point(32'h7fffffff, 32'h80000000, 32'hffffffff, 31'd103);
    evaluate(17'd0, 1'b0);
    evaluate(17'd131071, 1'b1);
    evaluate(17'd65536, 1'b0);
  endtask

  task automatic test_extrapolation();
    append_point(32'h00010000, 32'hffff0000, 32'h00050000, 31'd200003);
    evaluate(17'd0, 1'b0);
    evaluate(17'd0, 1'b1);
    evaluate(17'd500, 1'b0);
    evaluate(17'd500, 1'b1);
    evaluate(17'd1, 1'b0);
    evaluate(17'd40000, 1'b0);
    evaluate(17'd40000, 1'b1);
  endtask

  task automatic test_fill_table();
    logic [KNOT_W-1:0] k;
    while (ctrl_count < MAX_POINTS) begin
      k = KNOT_W'(ctrl_knot[ctrl_count-1] + (($urandom_range(0, 2) == 0) ?
          $urandom_range(1, 2000) : $urandom_range(1, 32'h07ffffff)));
      append_point(pick_coord(), pick_coord(), pick_coord(), k);
      evaluate(U_W'($urandom_range(0, 65536)), 1'($urandom));
    end
    append_point(pick_coord(), pick_coord(), pick_coord(), 31'h7fffffff);
  endtask

  task automatic test_random_items(int count);
    int n;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 2)
        append_point(pick_coord(), pick_coord(), pick_coord(), KNOT_W'($urandom));
      else if ($urandom_range(0, 9) == 0)
        evaluate(U_W'($urandom), 1'($urandom));
      else
        evaluate(U_W'($urandom_range(0, 65536)), 1'($urandom));
    end
  endtask

  task automatic test_output_hold();
    hold_requests++;
    test_random_items(10);
  endtask

  task automatic test_input_pause();
    in_valid <= 1'b0;
    wait_drained();
    test_random_items(6);
  endtask

  // receiver: shifting stall mix plus requested long holds
  always @(posedge clk) begin
    int stall_pct;
    stall_pct = ((cycles / 512) % 3 == 0) ? 0 : (((cycles / 512) % 3 == 1) ? 30 : 75);
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left <= 1500;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    spline_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result rx=%h ry=%h rz=%h status=%0d",
               out_rx, out_ry, out_rz, out_status);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        n_checked++;
        status_seen[out_status]++;
        if (out_rx !== exp_r.rx) begin
          $error("rx expected %h actual %h", exp_r.rx, out_rx);
          errors++;
        end
        if (out_ry !== exp_r.ry) begin
          $error("ry expected %h actual %h", exp_r.ry, out_ry);
          errors++;
        end
        if (out_rz !== exp_r.rz) begin
          $error("rz expected %h actual %h", exp_r.rz, out_rz);
          errors++;
        end
        if (out_status !== exp_r.st) begin
          $error("status expected %0d actual %0d", exp_r.st, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_too_few_points();
    test_extrapolation();
    test_fill_table();
    test_random_items(300);
    test_output_hold();
    test_random_items(300);
    test_input_pause();
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      errors++;
    end
    $display("Covered %0d appends and %0d evaluations, %0d results checked.",
             n_appends, n_evals, n_checked);
    $display("Status mix: ok %0d, full %0d, too few %0d, out of order %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/crs_pkg.sv
hdl/crs_store.sv
hdl/crs_div.sv
hdl/catmull_rom_spline_evaluator.sv
tb/catmull_rom_spline_evaluator_tb.sv
